>>> hw/rtl/dual_ring_byte_fifo_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual ring byte FIFO
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_RING_BYTE_FIFO_MACROS_SVH
`define DUAL_RING_BYTE_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRBF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/drbf_pkg.sv
// ----------------------------------------------------------------------------
// drbf_pkg
// Types and constants shared by the dual ring byte FIFO modules.
// ----------------------------------------------------------------------------
package drbf_pkg;

	localparam int DRBF_RING_DEPTH = 256;
	localparam int DRBF_RING_COUNT = 2;
	localparam int SIZE_W          = 9;
	localparam int FILL_W          = 8;
	localparam int BYTE_W          = 8;
	localparam int CFG_IDX_W       = 1;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TX_SIZE = 1'd0,
		CFG_RX_SIZE = 1'd1
	} cfg_idx_t;

	// Controller state: idle, or zeroing the slots of a cleared ring.
	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_CLEAR = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic              buffer_sel;
		logic [BYTE_W-1:0] data_in;
	} cmd_t;

	typedef struct packed {
		logic              ok;
		logic [BYTE_W-1:0] data_out;
		logic [FILL_W-1:0] fill_level;
	} rsp_t;

	// Status of the transaction in flight between the controller and the output.
	typedef struct packed {
		logic              valid;
		logic              pop_ok;
		logic              ok;
		logic [FILL_W-1:0] fill;
	} stage_t;

endpackage

>>> hw/rtl/drbf_ram.sv
// ----------------------------------------------------------------------------
// drbf_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module drbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

>>> hw/rtl/drbf_ctrl.sv
// ----------------------------------------------------------------------------
// drbf_ctrl
// Ring pointer registers, size registers, the push/pop/clear decision and the
// pass that zeroes the slots of a cleared ring.
// ----------------------------------------------------------------------------
module drbf_ctrl import drbf_pkg::*; #(
	parameter int RING_DEPTH = DRBF_RING_DEPTH,
	parameter int RING_COUNT = DRBF_RING_COUNT,
	localparam int ADDR_W = $clog2(RING_COUNT * RING_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_wdata,
	input  logic                 go,
	input  cmd_t                 cmd,
	output logic                 busy,
	output logic                 mem_en,
	output logic                 mem_we,
	output logic [ADDR_W-1:0]    mem_addr,
	output logic [BYTE_W-1:0]    mem_wdata,
	output stage_t               stage_s1
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int SZ_W  = (SIZE_W > IDX_W + 1) ? SIZE_W : IDX_W + 1;
	localparam int RIW   = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;

	logic [SIZE_W-1:0] tx_size_q, rx_size_q;
	logic [IDX_W-1:0]  head_q [RING_COUNT];
	logic [IDX_W-1:0]  tail_q [RING_COUNT];
	logic [FILL_W-1:0] fill_q [RING_COUNT];

	logic              ring_ok;
	logic [RIW-1:0]    ring_idx;
	logic [SZ_W-1:0]   size_raw, size_eff, size_last;
	logic [IDX_W-1:0]  head_cur, tail_cur, head_adv, tail_adv;
	logic [IDX_W-1:0]  head_d, tail_d;
	logic [FILL_W-1:0] fill_cur, fill_d;
	logic [SZ_W-1:0]   head_inc, tail_inc;
	logic              push_ok, pop_ok, ok, clr_go;

	ctrl_state_t       state_q, state_d;
	logic              clearing, clr_start;
	logic [RIW-1:0]    clr_ring_q;
	logic [IDX_W-1:0]  clr_idx_q, clr_last_q;
	logic [RIW-1:0]    addr_ring;
	logic [IDX_W-1:0]  addr_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_size_q <= SIZE_RESET;
			rx_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TX_SIZE: tx_size_q <= cfg_wdata;
				CFG_RX_SIZE: rx_size_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Only rings below RING_COUNT exist; others answer with all zeros.
	assign ring_ok  = (RING_COUNT > 1) || (cmd.buffer_sel == 1'b0);
	assign ring_idx = ring_ok ? RIW'(cmd.buffer_sel) : '0;

	always_comb begin
		if (ring_ok && cmd.buffer_sel == 1'b0) begin
			size_raw = SZ_W'(tx_size_q);
		end else if (ring_ok) begin
			size_raw = SZ_W'(rx_size_q);
		end else begin
			size_raw = SZ_W'(RING_DEPTH);
		end
		if (size_raw < SZ_W'(2)) begin
			size_eff = SZ_W'(2);
		end else if (size_raw > SZ_W'(RING_DEPTH)) begin
			size_eff = SZ_W'(RING_DEPTH);
		end else begin
			size_eff = size_raw;
		end
	end

	assign size_last = size_eff - SZ_W'(1);

	assign head_cur = head_q[ring_idx];
	assign tail_cur = tail_q[ring_idx];
	assign fill_cur = fill_q[ring_idx];
	assign head_inc = SZ_W'(head_cur) + SZ_W'(1);
	assign tail_inc = SZ_W'(tail_cur) + SZ_W'(1);
	assign head_adv = (head_inc >= size_eff) ? '0 : head_inc[IDX_W-1:0];
	assign tail_adv = (tail_inc >= size_eff) ? '0 : tail_inc[IDX_W-1:0];

	always_comb begin
		head_d  = head_cur;
		tail_d  = tail_cur;
		fill_d  = fill_cur;
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		ok      = 1'b0;
		clr_go  = 1'b0;
		case (opcode_t'(cmd.opcode))
			OP_PUSH: begin
				if (head_adv != tail_cur) begin
					push_ok = 1'b1;
					ok      = 1'b1;
					head_d  = head_adv;
					fill_d  = fill_cur + FILL_W'(1);
				end
			end
			OP_POP: begin
				if (head_cur != tail_cur) begin
					pop_ok = 1'b1;
					ok     = 1'b1;
					tail_d = tail_adv;
					fill_d = fill_cur - FILL_W'(1);
				end
			end
			OP_CLEAR: begin
				ok     = 1'b1;
				clr_go = 1'b1;
				head_d = '0;
				tail_d = '0;
				fill_d = '0;
			end
			default: ;
		endcase
		if (!ring_ok) begin
			push_ok = 1'b0;
			pop_ok  = 1'b0;
			ok      = 1'b0;
			clr_go  = 1'b0;
			fill_d  = '0;
		end
	end

	// A clear zeroes slots 0 to size-1 of its ring, one per cycle, while the
	// block reports busy.
	assign clr_start = go && clr_go;

	always_comb begin
		state_d  = state_q;
		clearing = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (clr_start) begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				clearing = 1'b1;
				if (clr_idx_q == clr_last_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_ring_q <= '0;
			clr_idx_q  <= '0;
			clr_last_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_start) begin
				clr_ring_q <= ring_idx;
				clr_idx_q  <= '0;
				clr_last_q <= size_last[IDX_W-1:0];
			end else if (clearing) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
		end
	end

	assign busy = clearing;

	// A push writes at the head slot, a pop reads the tail slot; never both.
	// The zeroing pass owns the store while it runs.
	assign mem_en    = clearing || (go && (push_ok || pop_ok));
	assign mem_we    = clearing || push_ok;
	assign addr_ring = clearing ? clr_ring_q : ring_idx;
	assign addr_slot = clearing ? clr_idx_q : (push_ok ? head_cur : tail_cur);
	assign mem_addr  = ADDR_W'(addr_ring) * ADDR_W'(RING_DEPTH) + ADDR_W'(addr_slot);
	assign mem_wdata = clearing ? '0 : cmd.data_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			stage_s1 <= '0;
		end else begin
			if (go && ring_ok) begin
				head_q[ring_idx] <= head_d;
				tail_q[ring_idx] <= tail_d;
				fill_q[ring_idx] <= fill_d;
			end
			stage_s1.valid  <= go;
			stage_s1.pop_ok <= go && pop_ok;
			stage_s1.ok     <= ok;
			stage_s1.fill   <= fill_d;
		end
	end

endmodule

>>> hw/rtl/dual_ring_byte_fifo.sv
// ----------------------------------------------------------------------------
// dual_ring_byte_fifo
// Two byte ring buffers, transmit and receive, sharing one byte store.
// ----------------------------------------------------------------------------
// Usage: a transaction is issued by holding start high with a command on cmd;
// it is taken at the rising edge where start is high and busy is low. The
// command selects a ring with buffer_sel and pushes data_in, pops a byte or
// clears the ring. Every transaction returns exactly one response on rsp,
// marked by done for a single cycle, in the cycle right after it was taken.
// The response carries ok, the popped byte (zero unless a pop succeeded) and
// the fill level of the selected ring after the operation.
// Pushes and pops are taken back to back: the pointers update at the taking
// edge and the store is a single-port RAM with a registered read, so the
// popped byte lands in the next cycle. A clear resets the pointers at once,
// then zeroes the slots below the ring's effective size (2 to RING_DEPTH) one
// per cycle with busy high, from the cycle after it was taken; its response
// still comes in that first cycle. The ring sizes are written on the
// cfg_we / cfg_index / cfg_wdata port while no transaction is in flight and
// busy is low. Reset sets both sizes to 256 and clears all pointers and fill
// counts; the store is not cleared. The user must read no entry before it
// has been written; the block does not enforce it. The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "dual_ring_byte_fifo_macros.svh"

module dual_ring_byte_fifo import drbf_pkg::*; #(
	parameter int RING_DEPTH = DRBF_RING_DEPTH,
	parameter int RING_COUNT = DRBF_RING_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_wdata,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 done,
	output rsp_t                 rsp
);

	localparam int STORE_DEPTH = RING_COUNT * RING_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	logic              go;
	logic              mem_en, mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [BYTE_W-1:0] mem_wdata, mem_rdata;
	stage_t            stage_s1;

	// Busy is high only while a cleared ring is being zeroed.
	assign go = start && !busy;

	drbf_ctrl #(
		.RING_DEPTH(RING_DEPTH),
		.RING_COUNT(RING_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.go       (go),
		.cmd      (cmd),
		.busy     (busy),
		.mem_en   (mem_en),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.stage_s1 (stage_s1)
	);

	// Both rings live in one store; ring r occupies the block starting at
	// r times RING_DEPTH.
	drbf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// The RAM output register holds the popped byte; it is shown only when the
	// transaction was a successful pop.
	assign done           = stage_s1.valid;
	assign rsp.ok         = stage_s1.ok;
	assign rsp.data_out   = stage_s1.pop_ok ? mem_rdata : '0;
	assign rsp.fill_level = stage_s1.fill;

	`DRBF_ASSERT_NEXT(a_one_rsp, go, done, "response missing after a transaction")
	`DRBF_ASSERT_NEXT(a_no_spurious, !go, !done, "response without a transaction")
	`DRBF_ASSERT_NOW(a_byte_on_ok, done && !rsp.ok, rsp.data_out == '0,
		"data returned on a refused operation")
	`DRBF_ASSERT_NEXT(a_clear_empty, go && cmd.opcode == OP_CLEAR && cmd.buffer_sel == 1'b0,
		rsp.ok && rsp.fill_level == '0, "clear did not empty the ring")

endmodule

>>> tb/sv/tb_dual_ring_byte_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_ring_byte_fifo
// Self-checking testbench for the two-ring byte FIFO. A behavioral copy of
// both rings predicts the response of every command taken on the start/busy
// handshake, and each response marked by done is checked against the oldest
// prediction. Directed commands cover empty and full rings, byte extremes,
// clears, the unused opcode and size saturation. Random traffic then fills,
// drains, clears and resizes the rings while the sender idles in phases.
// ----------------------------------------------------------------------------
module tb_dual_ring_byte_fifo;
	import drbf_pkg::*;

	// Opcode three has no operation behind it; the block must answer it with a
	// refusal and the current fill count.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int          CLK_HALF_NS = 5;
	localparam int          RESET_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int          MAX_REPORTED = 10;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0]    cfg_wdata;
	logic                 start;
	logic                 busy;
	cmd_t                 cmd;
	logic                 done;
	rsp_t                 rsp;

	// Shadow of the block: size registers, per-ring pointers and fill counts,
	// and the byte store. slot_written marks store entries that have been
	// written, by a push or by the zeroing of a clear; a pop is never aimed at
	// any other entry.
	logic [SIZE_W-1:0] shadow_size [DRBF_RING_COUNT];
	logic [7:0]        ring_head   [DRBF_RING_COUNT];
	logic [7:0]        ring_tail   [DRBF_RING_COUNT];
	logic [FILL_W-1:0] ring_fill   [DRBF_RING_COUNT];
	logic [BYTE_W-1:0] ring_bytes  [DRBF_RING_COUNT][DRBF_RING_DEPTH];
	bit                slot_written[DRBF_RING_COUNT][DRBF_RING_DEPTH];

	// Responses predicted for commands already taken, oldest first.
	rsp_t expected_rsp[$];

	int          mismatch_count = 0;
	int unsigned cycle_count = 0;

	dual_ring_byte_fifo u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.rsp       (rsp)
	);

	always begin
		#CLK_HALF_NS clk = 1'b1;
		#CLK_HALF_NS clk = 1'b0;
	end

	// The run must finish well inside this many cycles even with the sender
	// idling most of the time; hitting it means a handshake or a response hung.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses outstanding",
				cycle_count, expected_rsp.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Ring behavior
	// ------------------------------------------------------------------------

	// A size register outside 2..depth saturates to the nearest legal size.
	function automatic int ring_size(input int ring);
		int s;
		s = int'(shadow_size[ring]);
		if (s < 2)
			s = 2;
		if (s > DRBF_RING_DEPTH)
			s = DRBF_RING_DEPTH;
		return s;
	endfunction

	// Pointers wrap to zero once they reach the size. A pointer left beyond a
	// shrunken size still addresses its own slot and wraps on its next move.
	function automatic int next_index(input int idx, input int size);
		return (idx + 1 >= size) ? 0 : idx + 1;
	endfunction

	// Applies one command to the shadow rings and returns its response.
	function automatic rsp_t apply_ring_cmd(input cmd_t c);
		rsp_t r;
		int   ring;
		int   size;
		int   nxt;
		r    = '0;
		ring = int'(c.buffer_sel);
		size = ring_size(ring);
		case (c.opcode)
		OP_PUSH: begin
			// One slot always stays empty, so a full ring holds size-1 bytes.
			nxt = next_index(int'(ring_head[ring]), size);
			if (nxt != int'(ring_tail[ring])) begin
				ring_bytes[ring][ring_head[ring]]   = c.data_in;
				slot_written[ring][ring_head[ring]] = 1'b1;
				ring_head[ring] = 8'(nxt);
				ring_fill[ring] = ring_fill[ring] + 1'b1;
				r.ok = 1'b1;
			end
		end
		OP_POP: begin
			if (ring_head[ring] != ring_tail[ring]) begin
				r.data_out      = ring_bytes[ring][ring_tail[ring]];
				ring_tail[ring] = 8'(next_index(int'(ring_tail[ring]), size));
				ring_fill[ring] = ring_fill[ring] - 1'b1;
				r.ok = 1'b1;
			end
		end
		OP_CLEAR: begin
			// The slots below the ring's size are zeroed, and from then on they read as zero.
			ring_head[ring] = '0;
			ring_tail[ring] = '0;
			ring_fill[ring] = '0;
			for (int i = 0; i < size; i++) begin
				ring_bytes[ring][i]   = '0;
				slot_written[ring][i] = 1'b1;
			end
			r.ok = 1'b1;
		end
		default: begin
		end
		endcase
		r.fill_level = ring_fill[ring];
		return r;
	endfunction

	// Everything happens on the rising edge, on values that were settled before
	// it: a response is checked first, then a register write or a newly taken
	// command updates the shadow rings.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					if (mismatch_count < MAX_REPORTED)
						$display("%0t: response with no transaction pending: ok=%0b data=%02h fill=%0d",
							$time, rsp.ok, rsp.data_out, rsp.fill_level);
					mismatch_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.ok !== want.ok || rsp.data_out !== want.data_out ||
							rsp.fill_level !== want.fill_level) begin
						if (mismatch_count < MAX_REPORTED)
							$display("%0t: expected ok=%0b data=%02h fill=%0d, got ok=%0b data=%02h fill=%0d",
								$time, want.ok, want.data_out, want.fill_level,
								rsp.ok, rsp.data_out, rsp.fill_level);
						mismatch_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_TX_SIZE: shadow_size[0] <= cfg_wdata;
				CFG_RX_SIZE: shadow_size[1] <= cfg_wdata;
				default: begin
				end
				endcase
			end
			if (start && !busy)
				expected_rsp.push_back(apply_ring_cmd(cmd));
		end
	end

	// ------------------------------------------------------------------------
	// Drivers. Every task below is entered and left at a falling edge.
	// ------------------------------------------------------------------------

	function automatic cmd_t make_cmd(input logic [1:0] op, input logic sel,
			input logic [BYTE_W-1:0] data);
		cmd_t c;
		c.opcode     = op;
		c.buffer_sel = sel;
		c.data_in    = data;
		return c;
	endfunction

	// Holds the command with start high until the block takes it. start stays
	// high on return so that back-to-back transactions keep it asserted.
	task automatic send_cmd(input cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Waits until every taken transaction has answered and any zeroing pass
	// has ended, plus a short margin so that the block is surely quiet before
	// the sizes change.
	task automatic drain_responses();
		start <= 1'b0;
		while (expected_rsp.size() != 0 || busy)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Sizes are only written while the block is idle.
	task automatic set_sizes(input logic [SIZE_W-1:0] tx, input logic [SIZE_W-1:0] rx);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TX_SIZE;
		cfg_wdata <= tx;
		@(negedge clk);
		cfg_index <= CFG_RX_SIZE;
		cfg_wdata <= rx;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Draws a command from the given mix; whatever is left after push, pop and
	// clear goes to the unused opcode. A pop that would land on an entry that
	// was never written (only possible after a resize) becomes a push instead.
	function automatic cmd_t random_cmd(input int tx_pct, input int push_pct,
			input int pop_pct, input int clear_pct);
		int         roll;
		int         ring;
		logic [1:0] op;
		ring = ($urandom_range(0, 99) < tx_pct) ? 0 : 1;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			op = OP_PUSH;
		else if (roll < push_pct + pop_pct)
			op = OP_POP;
		else if (roll < push_pct + pop_pct + clear_pct)
			op = OP_CLEAR;
		else
			op = OP_UNUSED;
		if (op == OP_POP && ring_head[ring] != ring_tail[ring] &&
				!slot_written[ring][ring_tail[ring]])
			op = OP_PUSH;
		return make_cmd(op, ring[0], BYTE_W'($urandom_range(0, 255)));
	endfunction

	task automatic run_random_traffic(input int count, input int tx_pct,
			input int push_pct, input int pop_pct, input int clear_pct, input int idle_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < idle_pct)
				idle_cycles($urandom_range(1, 4));
			send_cmd(random_cmd(tx_pct, push_pct, pop_pct, clear_pct));
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Out of reset both rings are empty: pops are refused, and the unused
	// opcode reports the fill count without touching anything.
	task automatic test_empty_rings();
		send_cmd(make_cmd(OP_POP, 1'b0, 8'h00));
		send_cmd(make_cmd(OP_POP, 1'b1, 8'hFF));
		send_cmd(make_cmd(OP_UNUSED, 1'b0, 8'hFF));
		send_cmd(make_cmd(OP_UNUSED, 1'b1, 8'h00));
	endtask

	// Byte extremes through both rings in order, then a clear of each ring
	// while it still holds data.
	task automatic test_push_pop_extremes();
		send_cmd(make_cmd(OP_PUSH, 1'b0, 8'h00));
		send_cmd(make_cmd(OP_PUSH, 1'b0, 8'hFF));
		send_cmd(make_cmd(OP_PUSH, 1'b1, 8'hA5));
		send_cmd(make_cmd(OP_PUSH, 1'b1, 8'h5A));
		send_cmd(make_cmd(OP_POP, 1'b0, 8'h00));
		send_cmd(make_cmd(OP_UNUSED, 1'b0, 8'h00));
		send_cmd(make_cmd(OP_POP, 1'b1, 8'h00));
		send_cmd(make_cmd(OP_CLEAR, 1'b0, 8'h00));
		send_cmd(make_cmd(OP_CLEAR, 1'b1, 8'hFF));
		send_cmd(make_cmd(OP_POP, 1'b1, 8'h00));
	endtask

	// Sizes below two saturate to two, so each ring holds a single byte: the
	// second push is refused and the ring wraps on every move.
	task automatic test_size_saturation();
		drain_responses();
		set_sizes(9'd0, 9'd1);
		send_cmd(make_cmd(OP_PUSH, 1'b0, 8'h81));
		send_cmd(make_cmd(OP_PUSH, 1'b0, 8'h7E));
		send_cmd(make_cmd(OP_POP, 1'b0, 8'h00));
		send_cmd(make_cmd(OP_PUSH, 1'b1, 8'hC3));
		send_cmd(make_cmd(OP_PUSH, 1'b1, 8'h3C));
		send_cmd(make_cmd(OP_POP, 1'b1, 8'h00));
		send_cmd(make_cmd(OP_POP, 1'b1, 8'h00));
		// Sizes above the depth saturate to the full 256 slots.
		drain_responses();
		set_sizes(9'd511, 9'd257);
	endtask

	// Mostly pushes into the full-size transmit ring, so it reaches 255 bytes
	// and keeps refusing pushes; the sender idles most of the time.
	task automatic test_fill_to_full();
		run_random_traffic(320, 100, 95, 5, 0, 60);
	endtask

	// Shrinks both rings to tiny sizes while the transmit ring is nearly full,
	// then runs balanced back-to-back traffic with clears.
	task automatic test_small_rings();
		drain_responses();
		set_sizes(9'd5, 9'd2);
		run_random_traffic(200, 50, 45, 40, 7, 0);
	endtask

	// Grows both rings with data still in them.
	task automatic test_resize_in_use();
		drain_responses();
		set_sizes(9'd13, 9'd200);
		run_random_traffic(200, 50, 55, 35, 5, 18);
	endtask

	// Full-size transmit ring against a three-slot receive ring.
	task automatic test_mixed_traffic();
		drain_responses();
		set_sizes(9'd256, 9'd3);
		run_random_traffic(230, 60, 50, 40, 5, 60);
	endtask

	initial begin
		for (int r = 0; r < DRBF_RING_COUNT; r++) begin
			shadow_size[r] = SIZE_RESET;
			ring_head[r]   = '0;
			ring_tail[r]   = '0;
			ring_fill[r]   = '0;
			for (int i = 0; i < DRBF_RING_DEPTH; i++) begin
				ring_bytes[r][i]   = '0;
				slot_written[r][i] = 1'b0;
			end
		end
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_TX_SIZE;
		cfg_wdata = '0;
		start     = 1'b0;
		cmd       = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_rings();
		test_push_pop_extremes();
		test_size_saturation();
		test_fill_to_full();
		test_small_rings();
		test_resize_in_use();
		test_mixed_traffic();
		drain_responses();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
